### rtl/two_tone_fsk_bit_decider_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef TWO_TONE_FSK_BIT_DECIDER_MACROS_SVH
`define TWO_TONE_FSK_BIT_DECIDER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TTF_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define TTF_ASSERT(label, prop, msg) \
  `TTF_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/ttfsk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttfsk_pkg;

  localparam int unsigned MagW    = 16;
  localparam int unsigned RadW    = 32;
  localparam logic [15:0] ThrReset = 16'd10;

  typedef enum logic [1:0] {
    TONE_LOW  = 2'd0,
    TONE_HIGH = 2'd1,
    TONE_NONE = 2'd2
  } tone_e;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_NONE = 2'd2
  } sym_e;

  typedef struct packed {
    logic            start;
    logic [RadW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MagW-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

### rtl/ttfsk_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

`include "two_tone_fsk_bit_decider_macros.svh"

// Digit-by-digit integer square root, one result bit per cycle.
module ttfsk_sqrt (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ttfsk_pkg::sqrt_req_t req_i,
  output ttfsk_pkg::sqrt_rsp_t      rsp_o
);
  import ttfsk_pkg::*;

  localparam logic [RadW-1:0] BitInit = RadW'(1) << (RadW - 2);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [RadW-1:0] x_q, x_d;
  logic [RadW-1:0] root_q, root_d;
  logic [RadW-1:0] bit_q, bit_d;
  logic [RadW-1:0] trial;

  assign trial = root_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      x_d    = req_i.radicand;
      root_d = '0;
      bit_d  = BitInit;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d    = x_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == RadW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q[MagW-1:0];

  `TTF_ASSERT(a_start_when_idle, req_i.start |-> !busy_q, "sqrt started while busy")
  `TTF_ASSERT(a_done_after_busy, done_q |-> ($past(busy_q) && !busy_q), "stray sqrt done")
  `TTF_ASSERT(a_root_fits, done_q |-> (root_q[RadW-1:MagW] == '0), "root exceeds 16 bits")

endmodule

`default_nettype wire

### rtl/two_tone_fsk_bit_decider.sv
// Each item is accepted in IDLE; then the low bin and then the high bin each pass MUL_RE and
//   MUL_IM (squaring), SUM and ROOT on the shared root unit, then DECIDE, which waits while
//   the output register is full. A new item is accepted only back in IDLE, so the block does
//   not take a new item while it is still working on the last one.
// Reset (rst_ni, async, active low): threshold returns to 10, tone history and start flag
//   clear, output register empties; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "two_tone_fsk_bit_decider_macros.svh"

module two_tone_fsk_bit_decider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,   // silence_threshold
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // low_real[15:0], low_imag[31:16], high_real[47:32], high_imag[63:48]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tone_class[1:0], decoded_symbol[3:2], zero[7:4]
  output logic [7:0]       m_axis_tdata
);
  import ttfsk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RE,
    ST_MUL_IM,
    ST_SUM,
    ST_ROOT,
    ST_DECIDE
  } state_e;

  state_e             state_q;
  logic               bin_sel_q;      // 0 low bin, 1 high bin
  logic [15:0]        thr_q;
  logic [63:0]        bins_q;
  logic [30:0]        prod_q;
  logic [30:0]        sum_q;
  logic [MagW-1:0]    mag_low_q;
  logic [MagW-1:0]    mag_high_q;
  tone_e              cur_q;
  logic               start_q;
  logic               m_valid_q;
  tone_e              out_tone_q;
  sym_e               out_sym_q;

  logic signed [15:0] op;
  logic signed [31:0] sq;
  sqrt_req_t          sqrt_req;
  sqrt_rsp_t          sqrt_rsp;
  logic               out_free;
  tone_e              tone_new;
  sym_e               sym_new;
  logic               start_new;

  // Squarer operand: real part in MUL_RE, imaginary part otherwise.
  always_comb begin
    if (state_q == ST_MUL_RE) begin
      op = bin_sel_q ? signed'(bins_q[47:32]) : signed'(bins_q[15:0]);
    end else begin
      op = bin_sel_q ? signed'(bins_q[63:48]) : signed'(bins_q[31:16]);
    end
  end

  assign sq = op * op;

  assign sqrt_req.start    = (state_q == ST_SUM);
  assign sqrt_req.radicand = {1'b0, sum_q} + {1'b0, prod_q};

  ttfsk_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  always_comb begin
    tone_new  = TONE_HIGH;
    sym_new   = SYM_NONE;
    start_new = start_q;
    if ((mag_low_q < thr_q) && (mag_high_q < thr_q)) begin
      tone_new = TONE_NONE;
    end else if (mag_low_q > mag_high_q) begin
      tone_new = TONE_LOW;
    end
    if (tone_new == TONE_NONE) begin
      start_new = 1'b0;
    end else if (start_q) begin
      sym_new = (tone_new == TONE_LOW) ? SYM_ZERO : SYM_ONE;
    end else if (tone_new == TONE_LOW && cur_q == TONE_HIGH) begin
      start_new = 1'b1;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bin_sel_q <= 1'b0;
      thr_q     <= ThrReset;
      cur_q     <= TONE_LOW;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // DECIDE refills or keeps the output register itself
      if (m_valid_q && m_axis_tready && state_q != ST_DECIDE) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            bin_sel_q <= 1'b0;
            state_q   <= ST_MUL_RE;
          end
        end
        ST_MUL_RE: state_q <= ST_MUL_IM;
        ST_MUL_IM: state_q <= ST_SUM;
        ST_SUM:    state_q <= ST_ROOT;
        ST_ROOT: begin
          if (sqrt_rsp.done) begin
            if (bin_sel_q) begin
              state_q <= ST_DECIDE;
            end else begin
              bin_sel_q <= 1'b1;
              state_q   <= ST_MUL_RE;
            end
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            cur_q     <= tone_new;
            start_q   <= start_new;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      bins_q <= s_axis_tdata;
    end
    if (state_q == ST_MUL_RE || state_q == ST_MUL_IM) begin
      prod_q <= sq[30:0];   // a square of a 16-bit value is below 2^31
    end
    if (state_q == ST_MUL_IM) begin
      sum_q <= prod_q;
    end
    if (state_q == ST_ROOT && sqrt_rsp.done) begin
      if (bin_sel_q) begin
        mag_high_q <= sqrt_rsp.root;
      end else begin
        mag_low_q <= sqrt_rsp.root;
      end
    end
    if (state_q == ST_DECIDE && out_free) begin
      out_tone_q <= tone_new;
      out_sym_q  <= sym_new;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_sym_q, out_tone_q};

  `TTF_ASSERT(a_none_no_bit,
    m_valid_q |-> (out_tone_q != TONE_NONE || out_sym_q == SYM_NONE),
    "bit emitted for absent tone")
  `TTF_ASSERT(a_start_not_none, start_q |-> (cur_q != TONE_NONE), "start flag with absent tone")
  `TTF_ASSERT(a_done_in_root, sqrt_rsp.done |-> (state_q == ST_ROOT), "root done outside ROOT")
  `TTF_ASSERT(a_accept_starts,
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MUL_RE && !bin_sel_q),
    "accepted item did not start low bin")

endmodule

`default_nettype wire

### tb/sv/two_tone_fsk_bit_decider_tb.sv
`timescale 1ns / 1ps

module two_tone_fsk_bit_decider_tb;
  import ttfsk_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 400;

  typedef struct {
    tone_e tone;
    sym_e  sym;
  } tone_decision_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  // predictor state
  logic [15:0] silence_thr;
  tone_e       prev_tone;
  tone_e       cur_tone;
  logic        bit_run;
  tone_decision_t decisions_q[$];

  int cycle_count = 0;
  int err_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int bits_decoded = 0;
  int start_patterns = 0;
  int thr_writes = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  two_tone_fsk_bit_decider u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               decisions_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: stall modes of its own, plus a long hold on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(32, 300);
    end
    rx_mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 4) == 0);
        default: m_axis_tready = ((cycle_count % 9) < 4);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    end
    err_count++;
  endtask

  // truncated square root of re^2 + im^2, by bitwise search
  function automatic logic [15:0] bin_magnitude(input logic signed [15:0] re,
                                                input logic signed [15:0] im);
    longint pwr;
    longint root;
    longint cand;
    pwr = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= pwr) root = cand;
    end
    return root[15:0];
  endfunction

  function automatic void decide_tone_bit(input logic [15:0] lr, input logic [15:0] li,
                                          input logic [15:0] hr, input logic [15:0] hi);
    logic [15:0] mag_low;
    logic [15:0] mag_high;
    tone_decision_t d;
    mag_low = bin_magnitude(lr, li);
    mag_high = bin_magnitude(hr, hi);
    prev_tone = cur_tone;
    if (mag_low < silence_thr && mag_high < silence_thr) cur_tone = TONE_NONE;
    else if (mag_low > mag_high) cur_tone = TONE_LOW;
    else cur_tone = TONE_HIGH;
    d.tone = cur_tone;
    d.sym = SYM_NONE;
    if (cur_tone == TONE_NONE) begin
      bit_run = 1'b0;
    end else if (bit_run) begin
      d.sym = (cur_tone == TONE_LOW) ? SYM_ZERO : SYM_ONE;
      bits_decoded++;
    end else if (cur_tone == TONE_LOW && prev_tone == TONE_HIGH) begin
      bit_run = 1'b1;
      start_patterns++;
    end
    decisions_q.push_back(d);
  endfunction

  always @(posedge clk_i) begin
    tone_decision_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decisions_q.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
      end else begin
        want = decisions_q.pop_front();
        results_checked++;
        if (m_axis_tdata[1:0] != want.tone)
          report_mismatch("tone_class", m_axis_tdata[1:0], want.tone);
        if (m_axis_tdata[3:2] != want.sym)
          report_mismatch("decoded_symbol", m_axis_tdata[3:2], want.sym);
      end
    end
  end

  task automatic send_item(input logic [15:0] lr, input logic [15:0] li,
                           input logic [15:0] hr, input logic [15:0] hi);
    int gap;
    @(negedge clk_i);
    s_axis_tdata = {hi, hr, li, lr};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    decide_tone_bit(lr, li, hr, hi);
    items_sent++;
    if (!no_gaps) begin
      gap = 0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(1, 70);
        burst_left = $urandom_range(1, 10);
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 45);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_all_decided();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (decisions_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [15:0] thr);
    wait_all_decided();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = thr;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    silence_thr = thr;
    thr_writes++;
  endtask

  function automatic logic [15:0] rand_part(input int shift);
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> shift;
  endfunction

  // random content shaped toward one tone class
  task automatic send_tone(input tone_e t);
    int loud_shift;
    int faint_shift;
    loud_shift = $urandom_range(0, 3);
    faint_shift = $urandom_range(4, 15);
    case (t)
      TONE_LOW:  send_item(rand_part(loud_shift), rand_part(loud_shift),
                           rand_part(faint_shift), rand_part(faint_shift));
      TONE_HIGH: send_item(rand_part(faint_shift), rand_part(faint_shift),
                           rand_part(loud_shift), rand_part(loud_shift));
      default:   send_item(rand_part(15), rand_part(14), rand_part(15), rand_part(14));
    endcase
  endtask

  task automatic send_noise();
    send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_item(0, 0, 0, 0);
    send_item(9, 0, 0, 9);                  // both just under threshold
    send_item(10, 0, 0, 0);                 // low at threshold
    send_item(0, 0, -10, 0);
    send_item(7, 7, 0, 9);                  // root truncates to 9
    send_item(30, 40, 50, 0);               // equal magnitudes -> high
    send_item(-32768, -32768, 32767, 32767); // full scale, low wins, start
    send_item(32767, 32767, -32768, -32768);
    send_item(-32768, 0, 0, 32767);
    send_item(-32768, -32768, -32768, -32768);
    send_item(32767, -32768, -32768, 32767);
    send_item(1, -1, -1, 1);                // silence clears the run
    send_item(1000, 0, 0, 0);
    send_item(0, 0, 0, 1000);
    send_item(0, 0, 16'h5555, 16'hAAAA);
    send_item(16'hAAAA, 16'h5555, 0, 0);
    send_item(-1000, 3, 2, -5);
    send_item(0, 0, 0, 0);
  endtask

  task automatic test_threshold_extremes();
    set_threshold(16'd0);
    send_item(0, 0, 0, 0);                  // never silent at zero threshold
    send_item(1, 0, 0, 0);
    send_item(0, 0, 0, 0);
    send_item(0, -1, 0, 0);
    set_threshold(16'hFFFF);
    send_item(-32768, -32768, -32768, -32768);
    send_item(32767, 32767, 0, 0);
  endtask

  task automatic test_backpressure();
    wait_all_decided();
    no_gaps = 1'b1;
    @(posedge clk_i);
    hold_req = HoldCycles;
    send_tone(TONE_HIGH);
    send_tone(TONE_LOW);
    for (int i = 0; i < 8; i++) send_tone($urandom_range(0, 1) ? TONE_HIGH : TONE_LOW);
    send_tone(TONE_NONE);
    no_gaps = 1'b0;
    wait_all_decided();
  endtask

  task automatic test_random_frames();
    logic [15:0] thr_set[6];
    int          quota[6];
    int          phase_start;
    int          pick;
    int          n;
    thr_set = '{16'd10, 16'd1, 16'd300, 16'd0, 16'd0, 16'hFFFF};
    thr_set[3] = 16'($urandom_range(2, 2000));
    thr_set[4] = 16'($urandom);
    quota = '{150, 110, 130, 120, 50, 40};
    for (int p = 0; p < 6; p++) begin
      set_threshold(thr_set[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < quota[p]) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          n = $urandom_range(0, 2);
          repeat (n) send_tone(TONE_NONE);
          send_tone(TONE_HIGH);
          send_tone(TONE_LOW);
          n = $urandom_range(1, 10);
          repeat (n) send_tone($urandom_range(0, 1) ? TONE_HIGH : TONE_LOW);
          if ($urandom_range(0, 4) != 0) send_tone(TONE_NONE);
        end else if (pick < 9) begin
          send_noise();
        end else begin
          n = $urandom_range(2, 5);
          repeat (n) send_tone(tone_e'($urandom_range(0, 2)));
        end
      end
    end
  endtask

  initial begin
    silence_thr = ThrReset;
    prev_tone = TONE_LOW;
    cur_tone = TONE_LOW;
    bit_run = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_threshold_extremes();
    set_threshold(ThrReset);
    test_backpressure();
    test_random_frames();

    wait_all_decided();
    repeat (50) @(posedge clk_i);
    $display("covered %0d items, %0d results checked, %0d decoded bits, %0d bit runs",
             items_sent, results_checked, bits_decoded, start_patterns);
    $display("across %0d threshold settings incl. 0 and 65535, %0d mismatches",
             thr_writes, err_count);
    if (err_count == 0 && decisions_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
